// ===== sv/stff_pkg.sv =====
// Package for the first-free slot table: sizes, op and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package stff_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int OP_W   = 2;
    localparam int VAL_W  = 64;
    localparam int STAT_W = 2;
    localparam int LIVE_W = 5;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [LIVE_W-1:0] t_live;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [IDX_W-1:0]  t_idx;

    localparam t_op OP_ADD  = 2'd0;
    localparam t_op OP_PUSH = 2'd1;
    localparam t_op OP_DEL  = 2'd2;
    localparam t_op OP_POP  = 2'd3;

    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_MISS = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic decide;
        logic out_busy;
    } t_stat;

endpackage

// ===== sv/stff_ctrl.sv =====
// Controller for the slot table: idle/scan sequencing.
// Depends on stff_pkg.
`timescale 1ns / 1ps

module stff_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  stff_pkg::t_stat i_stat,
    output stff_pkg::t_cmd  o_cmd
);
    import stff_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.load    = i_in_valid && o_in_ready;
    assign o_cmd.commit  = (r_state == S_SCAN) && i_stat.decide && !i_stat.out_busy;
    assign o_cmd.step    = (r_state == S_SCAN) && !i_stat.decide;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/stff_dp.sv =====
// Datapath for the slot table: slot registers, scan index, result register.
// Depends on stff_pkg.
`timescale 1ns / 1ps

module stff_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stff_pkg::t_cmd    i_cmd,
    output stff_pkg::t_stat   o_stat,
    input  stff_pkg::t_op     i_op,
    input  stff_pkg::t_val    i_item_value,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output stff_pkg::t_status o_status,
    output stff_pkg::t_val    o_popped_value,
    output stff_pkg::t_live   o_live_count,
    output logic              o_is_empty
);
    import stff_pkg::*;

    t_val             r_data [SLOTS];
    logic [SLOTS-1:0] r_occ;
    t_cnt             r_len;
    t_cnt             r_count;
    t_cnt             r_idx;
    t_op              r_op;
    t_val             r_value;
    logic             r_out_valid;
    t_status          r_status;
    t_val             r_popped;
    t_live            r_live;
    logic             r_empty;

    t_status n_status;
    t_val    n_popped;
    t_cnt    n_count;

    logic w_end;
    logic w_match;
    logic w_insert;
    logic w_full;
    t_idx w_ri;
    t_idx w_li;
    logic w_fill;
    logic w_free;
    logic w_shift;
    logic w_append;

    assign w_ri     = r_idx[IDX_W-1:0];
    assign w_li     = r_len[IDX_W-1:0];
    assign w_end    = (r_idx == r_len);
    assign w_insert = (r_op == OP_ADD) || (r_op == OP_PUSH);
    assign w_full   = (r_len == CNT_W'(SLOTS));
    assign w_match  = !w_end && (w_insert ? !r_occ[w_ri]
                      : (r_occ[w_ri] && ((r_op == OP_POP) || (r_data[w_ri] == r_value))));

    assign o_stat.decide   = w_end || w_match;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        n_status = ST_MISS;
        n_popped = '0;
        n_count  = r_count;
        w_fill   = 1'b0;
        w_free   = 1'b0;
        w_shift  = 1'b0;
        w_append = 1'b0;
        if (w_match) begin
            n_status = ST_DONE;
            if (w_insert) begin
                w_fill  = 1'b1;
                n_count = r_count + 1'b1;
            end else begin
                w_free  = 1'b1;
                n_count = r_count - 1'b1;
                if (r_op == OP_POP) begin
                    n_popped = r_data[w_ri];
                end
            end
        end else if (w_insert) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_DONE;
                n_count  = r_count + 1'b1;
                if (r_op == OP_PUSH) begin
                    w_shift = 1'b1;
                end else begin
                    w_append = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_item_value;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_popped <= n_popped;
            r_live   <= LIVE_W'(n_count);
            r_empty  <= (n_count == '0);
            if (w_fill) begin
                r_data[w_ri] <= r_value;
            end else if (w_append) begin
                r_data[w_li] <= r_value;
            end else if (w_shift) begin
                for (int k = SLOTS - 1; k > 0; k--) begin
                    r_data[k] <= r_data[k-1];
                end
                r_data[0] <= r_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                if (w_fill) begin
                    r_occ[w_ri] <= 1'b1;
                end else if (w_free) begin
                    r_occ[w_ri] <= 1'b0;
                end else if (w_append) begin
                    r_occ[w_li] <= 1'b1;
                    r_len       <= r_len + 1'b1;
                end else if (w_shift) begin
                    for (int k = SLOTS - 1; k > 0; k--) begin
                        r_occ[k] <= r_occ[k-1];
                    end
                    r_occ[0] <= 1'b1;
                    r_len    <= r_len + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_live_count   = r_live;
    assign o_is_empty     = r_empty;

endmodule

// ===== sv/slot_table_first_free.sv =====
// Top level of the first-free slot table: controller plus datapath.
// Depends on stff_pkg, stff_ctrl, stff_dp.
//
//   channel  handshake                 payload
//   in       i_in_valid / o_in_ready   i_op, i_item_value
//   out      o_out_valid / i_out_ready o_status, o_popped_value, o_live_count, o_is_empty
//
// One beat is accepted in idle; the scan then examines the slots of the used prefix
// one by one, with the update done on the last slot that it examines.
// Reset clears occupied bits, prefix length, internal live count and output valid.
// A result waits in the output register; the next beat is accepted meanwhile,
// and its scan holds on its final slot until the output register is free.
`timescale 1ns / 1ps

module slot_table_first_free (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  stff_pkg::t_op     i_op,
    input  stff_pkg::t_val    i_item_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output stff_pkg::t_status o_status,
    output stff_pkg::t_val    o_popped_value,
    output stff_pkg::t_live   o_live_count,
    output logic              o_is_empty
);
    import stff_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    stff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    stff_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_op           (i_op),
        .i_item_value   (i_item_value),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_live_count   (o_live_count),
        .o_is_empty     (o_is_empty)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted during scan");

    a_commit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !o_in_ready)
        else $error("commit outside scan");

    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.commit))
        else $error("result without commit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_cmd.commit)
        else $error("result overwritten while stalled");
`endif

endmodule
